/* hdl/transport_stream_pid_filter_core_macros.svh */
// Assertion helpers shared by the filter modules. Each macro expects the
// enclosing module to have a clock named clk and an active-low reset rst_n.
`ifndef TRANSPORT_STREAM_PID_FILTER_CORE_MACROS_SVH
`define TRANSPORT_STREAM_PID_FILTER_CORE_MACROS_SVH

// Same-cycle implication.
`define TSPF_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TSPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tspf_pkg.sv */
package tspf_pkg;

  localparam int BYTE_W      = 8;
  localparam int PID_W       = 13;
  localparam int CC_W        = 4;
  localparam int PCR_W       = 48;
  localparam int MASK_W      = 4;
  localparam int CNT_W       = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int HDR_W       = 24;

  localparam int MAX_SLOTS           = 4;
  localparam int FILTER_SLOTS_DEF    = 4;
  localparam int QUEUE_DEPTH_DEF     = 4;

  localparam logic [BYTE_W-1:0] SYNC_PATTERN = 8'h47;

  // Bit positions inside the three header bytes that follow the sync byte.
  localparam int HDR_TEI_BIT   = 23;
  localparam int HDR_PUSI_BIT  = 22;
  localparam int HDR_PRIO_BIT  = 21;
  localparam int HDR_PID_LSB   = 8;
  localparam int HDR_SCR_MSB   = 7;
  localparam int HDR_SCR_LSB   = 6;
  localparam int HDR_AF_BIT    = 5;

  localparam int PCR_FLAG_BIT  = 4;
  localparam logic [BYTE_W-1:0] PCR_MIN_LEN  = 8'd7;
  localparam logic [BYTE_W-1:0] POS_LAST_HDR = 8'd3;
  localparam logic [BYTE_W-1:0] POS_AF_LEN   = 8'd4;
  localparam logic [BYTE_W-1:0] POS_AF_FLAGS = 8'd5;
  localparam logic [BYTE_W-1:0] POS_PCR_FIRST = 8'd6;
  localparam logic [BYTE_W-1:0] POS_PCR_LAST  = 8'd11;
  localparam logic [BYTE_W-1:0] POS_MAX       = 8'd255;

  typedef enum logic [1:0] {
    RK_INFO    = 2'd0,
    RK_PAYLOAD = 2'd1,
    RK_STATUS  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SYNC  = 2'd1,
    ST_TEI       = 2'd2,
    ST_SCRAMBLED = 2'd3
  } stat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_COUNT = 3'd0,
    CFG_PID_SLOT_0   = 3'd1,
    CFG_PID_SLOT_1   = 3'd2,
    CFG_PID_SLOT_2   = 3'd3,
    CFG_PID_SLOT_3   = 3'd4
  } cfg_idx_t;

  // Packet fields common to every result that one byte produces.
  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic              unit_start;
    logic              priority_bit;
    logic [CC_W-1:0]   continuity;
    logic [BYTE_W-1:0] flags;
    logic [PCR_W-1:0]  pcr;
    logic              pcr_valid;
    logic [MASK_W-1:0] mask;
  } pkt_info_t;

  // One queue entry: up to two results caused by one input byte.
  typedef struct packed {
    logic              first_valid;
    kind_t             first_kind;
    logic              has_status;
    stat_t             stat;
    logic [BYTE_W-1:0] data;
    pkt_info_t         info;
  } entry_t;

  typedef struct packed {
    kind_t             kind;
    stat_t             stat;
    logic [BYTE_W-1:0] data;
    logic              fin;
    pkt_info_t         info;
  } res_t;

endpackage

/* hdl/tspf_front.sv */
`include "transport_stream_pid_filter_core_macros.svh"

module tspf_front
  import tspf_pkg::*;
#(
  parameter int FILTER_SLOTS = FILTER_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept_i,
  input  logic [BYTE_W-1:0]     byte_i,
  input  logic                  eop_i,
  output logic                  push_o,
  output entry_t                entry_o
);

  logic [CNT_W-1:0] fc_r;
  logic [PID_W-1:0] slot_r [FILTER_SLOTS];

  logic [BYTE_W-1:0] pos_r, pos_nxt;
  logic [HDR_W-1:0]  hdr_r, hdr_nxt;
  logic [BYTE_W-1:0] alen_r, alen_nxt;
  logic [BYTE_W-1:0] flags_r, flags_nxt;
  logic [PCR_W-1:0]  pcr_r, pcr_nxt;
  logic [MASK_W-1:0] mask_r, mask_nxt;
  stat_t             stat_r, stat_nxt;
  logic              pay_r, pay_nxt;

  // Values after this byte is taken into account, before the end-of-packet clear.
  logic [HDR_W-1:0]  hdr_u;
  logic [BYTE_W-1:0] alen_u, flags_u;
  logic [PCR_W-1:0]  pcr_u;
  logic [MASK_W-1:0] mask_u, hits;
  stat_t             stat_u;
  logic              start;
  logic [CNT_W-1:0]  slots_on;
  logic              pcr_ok, payload_hit, info_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r <= '0;
      for (int i = 0; i < FILTER_SLOTS; i++) begin
        slot_r[i] <= '1;
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_FILTER_COUNT) begin
        fc_r <= cfg_data[CNT_W-1:0];
      end
      for (int i = 0; i < FILTER_SLOTS; i++) begin
        if (cfg_index == CFG_IDX_W'(int'(CFG_PID_SLOT_0) + i)) begin
          slot_r[i] <= cfg_data[PID_W-1:0];
        end
      end
    end
  end

  assign slots_on = (fc_r > CNT_W'(FILTER_SLOTS)) ? CNT_W'(FILTER_SLOTS) : fc_r;

  always_comb begin
    hits = '0;
    for (int i = 0; i < FILTER_SLOTS; i++) begin
      if ((CNT_W'(i) < slots_on) && (slot_r[i] == hdr_u[HDR_PID_LSB +: PID_W])) begin
        hits[i] = 1'b1;
      end
    end
  end

  always_comb begin
    hdr_u   = hdr_r;
    alen_u  = alen_r;
    flags_u = flags_r;
    pcr_u   = pcr_r;
    mask_u  = mask_r;
    stat_u  = stat_r;
    start   = 1'b0;
    if (!pay_r) begin
      if (pos_r == '0) begin
        stat_u = (byte_i != SYNC_PATTERN) ? ST_BAD_SYNC : ST_OK;
      end else if (pos_r <= POS_LAST_HDR) begin
        case (pos_r[1:0])
          2'd1:    hdr_u[23:16] = byte_i;
          2'd2:    hdr_u[15:8]  = byte_i;
          default: hdr_u[7:0]   = byte_i;
        endcase
        if (pos_r == POS_LAST_HDR) begin
          if (stat_u == ST_OK) begin
            if (hdr_u[HDR_TEI_BIT]) begin
              stat_u = ST_TEI;
            end else if (|hdr_u[HDR_SCR_MSB:HDR_SCR_LSB]) begin
              stat_u = ST_SCRAMBLED;
            end
          end
          if (stat_u == ST_OK) begin
            mask_u = hits;
          end
        end
      end else if (hdr_r[HDR_AF_BIT]) begin
        if (pos_r == POS_AF_LEN) begin
          alen_u = byte_i;
        end else if (pos_r == POS_AF_FLAGS && alen_r != '0) begin
          flags_u = byte_i;
        end else if (pos_r >= POS_PCR_FIRST && pos_r <= POS_PCR_LAST &&
                     alen_r >= PCR_MIN_LEN && flags_r[PCR_FLAG_BIT]) begin
          pcr_u = {pcr_r[PCR_W-BYTE_W-1:0], byte_i};
        end
      end
      // The payload starts after the header, or after the adaptation field
      // once its length is known; a zero-length field still skips its length byte.
      if (pos_r >= POS_LAST_HDR) begin
        if (!hdr_u[HDR_AF_BIT]) begin
          start = (pos_r == POS_LAST_HDR);
        end else begin
          start = (pos_r >= POS_AF_LEN) &&
                  ({1'b0, pos_r} == ({1'b0, POS_AF_LEN} + {1'b0, alen_u}));
        end
      end
    end
  end

  assign pcr_ok = hdr_u[HDR_AF_BIT] && (alen_u >= PCR_MIN_LEN) &&
                  flags_u[PCR_FLAG_BIT] && (pos_r >= POS_PCR_LAST);

  assign payload_hit = pay_r && (mask_r != '0);
  assign info_hit    = !pay_r && (mask_u != '0) &&
                       ((start && !eop_i) || (eop_i && pos_r >= POS_LAST_HDR));

  always_comb begin
    entry_o.first_valid       = payload_hit || info_hit;
    entry_o.first_kind        = payload_hit ? RK_PAYLOAD : RK_INFO;
    entry_o.has_status        = eop_i;
    entry_o.stat              = (pos_r < POS_LAST_HDR) ? ST_BAD_SYNC : stat_u;
    entry_o.data              = payload_hit ? byte_i : '0;
    entry_o.info.pid          = hdr_u[HDR_PID_LSB +: PID_W];
    entry_o.info.unit_start   = hdr_u[HDR_PUSI_BIT];
    entry_o.info.priority_bit = hdr_u[HDR_PRIO_BIT];
    entry_o.info.continuity   = hdr_u[CC_W-1:0];
    entry_o.info.flags        = flags_u;
    entry_o.info.pcr          = pcr_ok ? pcr_u : '0;
    entry_o.info.pcr_valid    = pcr_ok;
    entry_o.info.mask         = mask_u;
  end

  assign push_o = accept_i && (payload_hit || info_hit || eop_i);

  always_comb begin
    pos_nxt   = pos_r;
    hdr_nxt   = hdr_r;
    alen_nxt  = alen_r;
    flags_nxt = flags_r;
    pcr_nxt   = pcr_r;
    mask_nxt  = mask_r;
    stat_nxt  = stat_r;
    pay_nxt   = pay_r;
    if (accept_i) begin
      if (eop_i) begin
        pos_nxt   = '0;
        hdr_nxt   = '0;
        alen_nxt  = '0;
        flags_nxt = '0;
        pcr_nxt   = '0;
        mask_nxt  = '0;
        stat_nxt  = ST_OK;
        pay_nxt   = 1'b0;
      end else begin
        pos_nxt   = (pos_r == POS_MAX) ? pos_r : pos_r + 8'd1;
        hdr_nxt   = hdr_u;
        alen_nxt  = alen_u;
        flags_nxt = flags_u;
        pcr_nxt   = pcr_u;
        mask_nxt  = mask_u;
        stat_nxt  = stat_u;
        pay_nxt   = pay_r || start;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      hdr_r   <= '0;
      alen_r  <= '0;
      flags_r <= '0;
      pcr_r   <= '0;
      mask_r  <= '0;
      stat_r  <= ST_OK;
      pay_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      hdr_r   <= hdr_nxt;
      alen_r  <= alen_nxt;
      flags_r <= flags_nxt;
      pcr_r   <= pcr_nxt;
      mask_r  <= mask_nxt;
      stat_r  <= stat_nxt;
      pay_r   <= pay_nxt;
    end
  end

  `TSPF_ASSERT_HOLDS(a_payload_after_header, pay_r, pos_r > POS_LAST_HDR, "payload before header end")
  `TSPF_ASSERT_HOLDS(a_mask_only_when_ok, mask_r != '0, stat_r == ST_OK, "match on errored packet")

endmodule

/* hdl/tspf_queue.sv */
`include "transport_stream_pid_filter_core_macros.svh"

module tspf_queue
  import tspf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_en,
  input  entry_t wr_data,
  output logic   full_o,
  input  logic   rd_en,
  output entry_t rd_data,
  output logic   empty_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(QUEUE_DEPTH);

  entry_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]  cnt_r, cnt_nxt;

  assign full_o  = (cnt_r == CNT_FULL);
  assign empty_o = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `TSPF_ASSERT_HOLDS(a_no_write_when_full, wr_en, !full_o, "queue overrun")
  `TSPF_ASSERT_HOLDS(a_no_read_when_empty, rd_en, !empty_o, "queue underrun")

endmodule

/* hdl/tspf_back.sv */
`include "transport_stream_pid_filter_core_macros.svh"

module tspf_back
  import tspf_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   q_empty_i,
  input  entry_t q_data_i,
  output logic   q_pop_o,
  input  logic   out_pop_i,
  output logic   out_empty_o,
  output res_t   out_res_o
);

  logic   ov_r, ov_nxt;
  logic   phase_r, phase_nxt;
  res_t   res_r, res_nxt;
  logic   load, sel_status;

  // A result moves into the output register whenever that register is free
  // or is being emptied in this cycle.
  assign load       = !q_empty_i && (!ov_r || out_pop_i);
  assign sel_status = phase_r || !q_data_i.first_valid;
  assign q_pop_o    = load && (sel_status || !q_data_i.has_status);

  always_comb begin
    res_nxt.info = q_data_i.info;
    if (sel_status) begin
      res_nxt.kind = RK_STATUS;
      res_nxt.stat = q_data_i.stat;
      res_nxt.data = '0;
      res_nxt.fin  = 1'b1;
    end else begin
      res_nxt.kind = q_data_i.first_kind;
      res_nxt.stat = ST_OK;
      res_nxt.data = q_data_i.data;
      res_nxt.fin  = (q_data_i.first_kind == RK_PAYLOAD) && q_data_i.has_status;
    end
  end

  always_comb begin
    ov_nxt    = ov_r;
    phase_nxt = phase_r;
    if (load) begin
      ov_nxt    = 1'b1;
      phase_nxt = !sel_status && q_data_i.has_status;
    end else if (out_pop_i) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r    <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      ov_r    <= ov_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign out_empty_o = !ov_r;
  assign out_res_o   = res_r;

  `TSPF_ASSERT_HOLDS(a_phase_has_entry, phase_r,
    !q_empty_i && q_data_i.first_valid && q_data_i.has_status, "second result without entry")
  `TSPF_ASSERT_NEXT(a_status_ends_entry, load && sel_status, !phase_r, "entry not retired")

endmodule

/* hdl/transport_stream_pid_filter_core.sv */
// Transport stream PID filter. Packet bytes enter one beat per clock on the
// in_ side, header first, with in_end_of_packet on the last byte; the block
// accepts a byte in every cycle while in_full is low, and results leave one
// beat per clock on the out_ side while out_pop is high. The front parser
// checks sync, the transport error bit and scrambling, skips the adaptation
// field while keeping its flags byte and PCR, and compares the PID against
// the enabled filter slots. Every byte of a matching, error-free packet after
// the header and adaptation field comes out as a payload beat, preceded by
// one info beat; the last byte of every packet adds a status beat. A result
// passes through the queue and then the output register. The end-of-packet
// byte may cause two results, so the output side falls one beat behind; a
// queue of QUEUE_DEPTH entries between parser and output register absorbs
// that, and in_full rises only when it is full. Configuration registers are
// written through cfg_we, cfg_index and cfg_data and must only change while
// no packet is in flight.

module transport_stream_pid_filter_core
  import tspf_pkg::*;
#(
  parameter int FILTER_SLOTS = FILTER_SLOTS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input byte channel.
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [BYTE_W-1:0]     in_packet_byte,
  input  logic                  in_end_of_packet,
  // Result channel.
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [1:0]            out_result_kind,
  output logic [1:0]            out_status,
  output logic [PID_W-1:0]      out_packet_pid,
  output logic                  out_unit_start,
  output logic                  out_priority_bit,
  output logic [CC_W-1:0]       out_continuity,
  output logic [BYTE_W-1:0]     out_adaptation_flags,
  output logic [PCR_W-1:0]      out_clock_reference,
  output logic                  out_clock_valid,
  output logic [MASK_W-1:0]     out_match_mask,
  output logic [BYTE_W-1:0]     out_payload_data,
  output logic                  out_final_flag
);

  logic   q_full, q_empty, q_pop, push, accept;
  entry_t push_entry, head_entry;
  res_t   res;

  // A byte beat is taken whenever the queue has room for what it may cause.
  assign accept  = in_push && !q_full;
  assign in_full = q_full;

  tspf_front #(
    .FILTER_SLOTS (FILTER_SLOTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept_i  (accept),
    .byte_i    (in_packet_byte),
    .eop_i     (in_end_of_packet),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  tspf_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (push_entry),
    .full_o  (q_full),
    .rd_en   (q_pop),
    .rd_data (head_entry),
    .empty_o (q_empty)
  );

  tspf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty_i   (q_empty),
    .q_data_i    (head_entry),
    .q_pop_o     (q_pop),
    .out_pop_i   (out_pop),
    .out_empty_o (out_empty),
    .out_res_o   (res)
  );

  // The output register carries every field of the result beat.
  assign out_result_kind      = res.kind;
  assign out_status           = res.stat;
  assign out_packet_pid       = res.info.pid;
  assign out_unit_start       = res.info.unit_start;
  assign out_priority_bit     = res.info.priority_bit;
  assign out_continuity       = res.info.continuity;
  assign out_adaptation_flags = res.info.flags;
  assign out_clock_reference  = res.info.pcr;
  assign out_clock_valid      = res.info.pcr_valid;
  assign out_match_mask       = res.info.mask;
  assign out_payload_data     = res.data;
  assign out_final_flag       = res.fin;

endmodule

/* tb/transport_stream_pid_filter_core_test.sv */
module transport_stream_pid_filter_core_test;
  import tspf_pkg::*;

  // Generous cycle budget. The slowest correct run (every byte and every
  // result beat waiting out the longest stall) stays far below it.
  localparam int CYCLE_LIMIT = 400000;

  // Shadow of the filter: its own copy of the slot registers and packet
  // state, the beats it expects, and the mismatch count.
  class ts_filter_shadow;
    logic [CNT_W-1:0]  active_slots;
    logic [PID_W-1:0]  slot_pid [MAX_SLOTS];
    logic [BYTE_W-1:0] pos;
    logic [HDR_W-1:0]  hdr;
    logic [BYTE_W-1:0] af_len;
    logic [BYTE_W-1:0] af_flags;
    logic [PCR_W-1:0]  pcr_bytes;
    logic [MASK_W-1:0] hit_mask;
    stat_t             pkt_stat;
    bit                payload_on;
    res_t              awaited_beats [$];
    int                mismatches;
    int                info_seen;
    int                payload_seen;
    int                status_seen;

    function new();
      active_slots = '0;
      foreach (slot_pid[i]) slot_pid[i] = '1;
      start_packet();
      mismatches = 0;
      info_seen = 0;
      payload_seen = 0;
      status_seen = 0;
    endfunction

    function void start_packet();
      pos = '0;
      hdr = '0;
      af_len = '0;
      af_flags = '0;
      pcr_bytes = '0;
      hit_mask = '0;
      pkt_stat = ST_OK;
      payload_on = 1'b0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_FILTER_COUNT: active_slots = value[CNT_W-1:0];
        CFG_PID_SLOT_0:   slot_pid[0] = value;
        CFG_PID_SLOT_1:   slot_pid[1] = value;
        CFG_PID_SLOT_2:   slot_pid[2] = value;
        CFG_PID_SLOT_3:   slot_pid[3] = value;
        default: ;
      endcase
    endfunction

    // A slot count above the number of slots simply enables all of them.
    function logic [MASK_W-1:0] slot_hits(logic [PID_W-1:0] pid);
      int n;
      logic [MASK_W-1:0] m;
      n = (active_slots > FILTER_SLOTS_DEF) ? FILTER_SLOTS_DEF : active_slots;
      m = '0;
      for (int i = 0; i < n; i++)
        if (slot_pid[i] == pid) m[i] = 1'b1;
      return m;
    endfunction

    function res_t form_beat(kind_t k, stat_t s, logic [BYTE_W-1:0] d, bit fin, int p);
      res_t r;
      bit clock_ok;
      clock_ok = hdr[HDR_AF_BIT] && af_len >= PCR_MIN_LEN && af_flags[PCR_FLAG_BIT] &&
                 p >= POS_PCR_LAST;
      r.kind = k;
      r.stat = s;
      r.data = d;
      r.fin = fin;
      r.info.pid = hdr[HDR_PID_LSB +: PID_W];
      r.info.unit_start = hdr[HDR_PUSI_BIT];
      r.info.priority_bit = hdr[HDR_PRIO_BIT];
      r.info.continuity = hdr[CC_W-1:0];
      r.info.flags = af_flags;
      r.info.pcr = clock_ok ? pcr_bytes : '0;
      r.info.pcr_valid = clock_ok;
      r.info.mask = hit_mask;
      return r;
    endfunction

    // Works out the beats caused by one accepted byte.
    function void note_byte(logic [BYTE_W-1:0] b, bit eop);
      int p;
      int last;
      bit was_payload;
      bit af;
      bit known;
      p = pos;
      was_payload = payload_on;
      af = hdr[HDR_AF_BIT];
      if (was_payload) begin
        if (hit_mask != 0) awaited_beats.push_back(form_beat(RK_PAYLOAD, ST_OK, b, eop, p));
      end else begin
        if (p == 0) begin
          pkt_stat = (b != SYNC_PATTERN) ? ST_BAD_SYNC : ST_OK;
        end else if (p <= POS_LAST_HDR) begin
          hdr = hdr | (HDR_W'(b) << (8 * (POS_LAST_HDR - p)));
          if (p == POS_LAST_HDR) begin
            if (pkt_stat == ST_OK) begin
              if (hdr[HDR_TEI_BIT]) pkt_stat = ST_TEI;
              else if (hdr[HDR_SCR_MSB:HDR_SCR_LSB] != 0) pkt_stat = ST_SCRAMBLED;
            end
            if (pkt_stat == ST_OK) hit_mask = slot_hits(hdr[HDR_PID_LSB +: PID_W]);
            af = hdr[HDR_AF_BIT];
          end
        end else if (af) begin
          if (p == POS_AF_LEN)
            af_len = b;
          else if (p == POS_AF_FLAGS && af_len >= 1)
            af_flags = b;
          else if (p >= POS_PCR_FIRST && p <= POS_PCR_LAST && af_len >= PCR_MIN_LEN &&
                   af_flags[PCR_FLAG_BIT])
            pcr_bytes = {pcr_bytes[PCR_W-BYTE_W-1:0], b};
        end
        if (p >= POS_LAST_HDR) begin
          known = 1'b1;
          last = POS_LAST_HDR;
          if (af) begin
            if (p >= POS_AF_LEN) last = POS_AF_LEN + af_len;
            else known = 1'b0;
          end
          if (known && p == last) begin
            payload_on = 1'b1;
            if (!eop && hit_mask != 0)
              awaited_beats.push_back(form_beat(RK_INFO, ST_OK, '0, 1'b0, p));
          end
        end
      end
      if (eop) begin
        // The info beat of a packet that ends before its payload comes with the status.
        if (!was_payload && hit_mask != 0 && p >= POS_LAST_HDR)
          awaited_beats.push_back(form_beat(RK_INFO, ST_OK, '0, 1'b0, p));
        awaited_beats.push_back(form_beat(RK_STATUS, (p < POS_LAST_HDR) ? ST_BAD_SYNC : pkt_stat,
                                          '0, 1'b1, p));
        start_packet();
      end else if (pos != POS_MAX) begin
        pos++;
      end
    endfunction

    task report(string msg);
      mismatches++;
      $display("ERROR: %s", msg);
    endtask

    task compare_field(string name, logic [PCR_W-1:0] got, logic [PCR_W-1:0] want);
      if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task check_beat(res_t got);
      res_t want;
      if (awaited_beats.size() == 0) begin
        report($sformatf("result beat of kind %0d arrived with nothing pending", got.kind));
        return;
      end
      want = awaited_beats.pop_front();
      compare_field("result_kind", got.kind, want.kind);
      compare_field("status", got.stat, want.stat);
      compare_field("payload_data", got.data, want.data);
      compare_field("final_flag", got.fin, want.fin);
      compare_field("packet_pid", got.info.pid, want.info.pid);
      compare_field("unit_start", got.info.unit_start, want.info.unit_start);
      compare_field("priority_bit", got.info.priority_bit, want.info.priority_bit);
      compare_field("continuity", got.info.continuity, want.info.continuity);
      compare_field("adaptation_flags", got.info.flags, want.info.flags);
      compare_field("clock_reference", got.info.pcr, want.info.pcr);
      compare_field("clock_valid", got.info.pcr_valid, want.info.pcr_valid);
      compare_field("match_mask", got.info.mask, want.info.mask);
      case (want.kind)
        RK_INFO:    info_seen++;
        RK_PAYLOAD: payload_seen++;
        default:    status_seen++;
      endcase
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_index = CFG_FILTER_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic [BYTE_W-1:0]     in_packet_byte = '0;
  logic                  in_end_of_packet = 1'b0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic [1:0]            out_result_kind;
  logic [1:0]            out_status;
  logic [PID_W-1:0]      out_packet_pid;
  logic                  out_unit_start;
  logic                  out_priority_bit;
  logic [CC_W-1:0]       out_continuity;
  logic [BYTE_W-1:0]     out_adaptation_flags;
  logic [PCR_W-1:0]      out_clock_reference;
  logic                  out_clock_valid;
  logic [MASK_W-1:0]     out_match_mask;
  logic [BYTE_W-1:0]     out_payload_data;
  logic                  out_final_flag;

  ts_filter_shadow   filter_chk;
  logic [BYTE_W-1:0] pkt_bytes [$];
  logic [CNT_W-1:0]  count_cfg;
  logic [PID_W-1:0]  slot_cfg [MAX_SLOTS];
  int                cycle_count = 0;
  int                bytes_sent = 0;
  int                packets_sent = 0;
  int                settings_used = 0;
  // Idle controls: the phase switches each side on or off, and every packet
  // picks whether it sees gaps, so calm stretches mix with bursty ones.
  bit                tx_gaps_on = 1'b0;
  bit                rx_stalls_on = 1'b0;
  bit                pkt_gaps = 1'b0;
  bit                rx_calm = 1'b0;

  transport_stream_pid_filter_core uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_packet_byte      (in_packet_byte),
    .in_end_of_packet    (in_end_of_packet),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_result_kind     (out_result_kind),
    .out_status          (out_status),
    .out_packet_pid      (out_packet_pid),
    .out_unit_start      (out_unit_start),
    .out_priority_bit    (out_priority_bit),
    .out_continuity      (out_continuity),
    .out_adaptation_flags(out_adaptation_flags),
    .out_clock_reference (out_clock_reference),
    .out_clock_valid     (out_clock_valid),
    .out_match_mask      (out_match_mask),
    .out_payload_data    (out_payload_data),
    .out_final_flag      (out_final_flag)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog. A hung handshake or a missing beat ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side. The port values seen at a rising edge are the ones the
  // block presented before it, so a beat is taken exactly when pop was high
  // and empty low at that edge. Stall bursts keep pop low, which is what
  // backs the queue up far enough to raise in_full.
  initial begin
    res_t got;
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_stalls_on && !rx_calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 15);
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      if (out_empty === 1'b0) begin
        got.kind = kind_t'(out_result_kind);
        got.stat = stat_t'(out_status);
        got.data = out_payload_data;
        got.fin = out_final_flag;
        got.info.pid = out_packet_pid;
        got.info.unit_start = out_unit_start;
        got.info.priority_bit = out_priority_bit;
        got.info.continuity = out_continuity;
        got.info.flags = out_adaptation_flags;
        got.info.pcr = out_clock_reference;
        got.info.pcr_valid = out_clock_valid;
        got.info.mask = out_match_mask;
        filter_chk.check_beat(got);
      end
    end
  end

  // Writes all five registers back to back. Only called while no packet is
  // in flight, so the shadow can take each value at its write edge.
  task automatic program_filters();
    cfg_idx_t slot_reg [MAX_SLOTS];
    slot_reg = '{CFG_PID_SLOT_0, CFG_PID_SLOT_1, CFG_PID_SLOT_2, CFG_PID_SLOT_3};
    cfg_we <= 1'b1;
    cfg_index <= CFG_FILTER_COUNT;
    cfg_data <= CFG_DATA_W'(count_cfg);
    @(posedge clk);
    filter_chk.write_reg(CFG_FILTER_COUNT, CFG_DATA_W'(count_cfg));
    for (int i = 0; i < MAX_SLOTS; i++) begin
      cfg_index <= slot_reg[i];
      cfg_data <= slot_cfg[i];
      @(posedge clk);
      filter_chk.write_reg(slot_reg[i], slot_cfg[i]);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Offers one byte and holds it until the block takes it. The push line is
  // only lowered for a gap, so back-to-back beats never toggle it.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit eop);
    int gap;
    if (tx_gaps_on && pkt_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_packet_byte <= b;
    in_end_of_packet <= eop;
    @(posedge clk);
    while (in_full) @(posedge clk);
    filter_chk.note_byte(b, eop);
    bytes_sent++;
  endtask

  task automatic send_packet();
    pkt_gaps = ($urandom_range(0, 3) != 0);
    rx_calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < pkt_bytes.size(); i++)
      send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    packets_sent++;
  endtask

  // Stops offering bytes and waits until every pending beat has come out.
  // A byte that causes no beat can still be inside the parser at that point,
  // so the task keeps idling after that before the registers may change.
  task automatic drain_results();
    in_push <= 1'b0;
    while (filter_chk.awaited_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Builds one packet into pkt_bytes. Most packets are well formed, with the
  // PID usually taken from the slot registers so that payload flows; about
  // one in ten is short junk, and some are cut off at a random byte, so the
  // end marker can fall in the header, the adaptation field or the payload.
  function automatic void build_packet(bit long_one);
    logic [PID_W-1:0]  pid;
    logic [BYTE_W-1:0] field_len;
    logic [1:0]        scramble;
    bit                af;
    bit                tei;
    int                pay_len;
    int                fill;
    int                keep;
    int                n;
    pkt_bytes.delete();
    if (!long_one && $urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) pkt_bytes.push_back(BYTE_W'($urandom));
      return;
    end
    if (long_one) pid = slot_cfg[0];
    else if ($urandom_range(0, 99) < 65) pid = slot_cfg[$urandom_range(0, MAX_SLOTS - 1)];
    else pid = PID_W'($urandom);
    af = long_one ? 1'b0 : 1'($urandom);
    tei = long_one ? 1'b0 : ($urandom_range(0, 11) == 0);
    scramble = (!long_one && $urandom_range(0, 7) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
    if (!long_one && $urandom_range(0, 19) == 0) pkt_bytes.push_back(BYTE_W'($urandom));
    else pkt_bytes.push_back(SYNC_PATTERN);
    pkt_bytes.push_back({tei, 1'($urandom), 1'($urandom), pid[PID_W-1:BYTE_W]});
    pkt_bytes.push_back(pid[BYTE_W-1:0]);
    pkt_bytes.push_back({scramble, af, 1'($urandom), 4'($urandom)});
    pay_len = long_one ? 300 : $urandom_range(0, 24);
    if (af) begin
      case ($urandom_range(0, 9))
        0:          field_len = 8'd0;
        1, 2:       field_len = BYTE_W'($urandom_range(1, 6));
        3, 4, 5, 6: field_len = BYTE_W'($urandom_range(7, 12));
        7:          field_len = BYTE_W'($urandom_range(13, 255));
        default:    field_len = PCR_MIN_LEN;
      endcase
      pkt_bytes.push_back(field_len);
      // The PCR flag is set in most flags bytes so that the clock is carried.
      if (field_len >= 1)
        pkt_bytes.push_back(($urandom_range(0, 9) < 7) ? (BYTE_W'($urandom) | 8'h10)
                                                       : BYTE_W'($urandom));
      fill = (field_len > 1) ? field_len - 1 : 0;
      // A long field is always cut short by the end marker, leaving no payload.
      if (field_len > 40) begin
        fill = $urandom_range(0, 20);
        pay_len = 0;
      end
      repeat (fill) pkt_bytes.push_back(BYTE_W'($urandom));
    end
    repeat (pay_len) pkt_bytes.push_back(BYTE_W'($urandom));
    if (!long_one && $urandom_range(0, 6) == 0) begin
      keep = $urandom_range(1, pkt_bytes.size());
      while (pkt_bytes.size() > keep) void'(pkt_bytes.pop_back());
    end
  endfunction

  task automatic run_random(input int budget, input bit with_long);
    int first;
    first = bytes_sent;
    if (with_long) begin
      build_packet(1'b1);
      send_packet();
    end
    while (bytes_sent - first < budget) begin
      build_packet(1'b0);
      send_packet();
    end
  endtask

  // Short directed packets against slots {0, 8191, 0x1555, 0x1555}: a lone
  // sync byte, a header-only match on PID 8191, a zero-length adaptation
  // field matching two slots, a transport error, and a full PCR whose field
  // ends on the final byte with 0x00/0xff extremes in the clock.
  task automatic send_directed();
    pkt_bytes = '{8'h47};
    send_packet();
    pkt_bytes = '{8'h47, 8'h5f, 8'hff, 8'h1f};
    send_packet();
    pkt_bytes = '{8'h47, 8'h35, 8'h55, 8'h30, 8'h00, 8'ha5};
    send_packet();
    pkt_bytes = '{8'h47, 8'h80, 8'h00, 8'h10};
    send_packet();
    pkt_bytes = '{8'h47, 8'h00, 8'h00, 8'h3a, 8'h07, 8'h10,
                  8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff};
    send_packet();
  endtask

  initial begin
    int phase_counts [6];
    phase_counts = '{3'd7, 3'd1, 3'd3, 3'd2, 3'd4, 3'd5};
    filter_chk = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values first: no slot is active, so only status beats come out.
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    run_random(60, 1'b0);
    drain_results();

    count_cfg = 3'd4;
    slot_cfg = '{13'h0000, 13'h1fff, 13'h1555, 13'h1555};
    program_filters();
    send_directed();
    drain_results();

    // Random phases with fresh filter settings, including slot counts above
    // the number of slots, duplicate PIDs and the PID extremes. The second
    // phase carries one very long packet whose byte position saturates. The
    // last phase runs with both sides at full speed.
    for (int phase = 0; phase < 6; phase++) begin
      count_cfg = phase_counts[phase];
      foreach (slot_cfg[i]) begin
        case ($urandom_range(0, 5))
          0:       slot_cfg[i] = '0;
          1:       slot_cfg[i] = '1;
          2:       slot_cfg[i] = (i > 0) ? slot_cfg[0] : PID_W'($urandom);
          default: slot_cfg[i] = PID_W'($urandom);
        endcase
      end
      if (phase == 5) begin
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
      end
      program_filters();
      run_random(180, phase == 1);
      drain_results();
    end
    repeat (20) @(posedge clk);

    if (filter_chk.awaited_beats.size() != 0)
      filter_chk.report($sformatf("%0d result beats never arrived",
                                  filter_chk.awaited_beats.size()));
    $display("Run covered %0d bytes in %0d packets under %0d filter settings.",
             bytes_sent, packets_sent, settings_used);
    $display("Beats compared: %0d info, %0d payload, %0d status; %0d mismatches.",
             filter_chk.info_seen, filter_chk.payload_seen, filter_chk.status_seen,
             filter_chk.mismatches);
    if (filter_chk.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
